// File: src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

   localparam int COORD_W           = 6;
   localparam int COLOR_W           = 8;
   localparam int GRID_SIZE_DEFAULT = 64;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               last_pixel;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture a new line request
      logic advance;  // step to the next pixel
   } dlr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;     // the pixel on the output is the final one
   } dlr_status_type;

endpackage

// File: src/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// Handshake controller: accepts a request, walks the line one pixel per
// accepted item, and releases the input side on the final pixel.
// ----------------------------------------------------------------------------
module dlr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dlr_pkg::dlr_status_type status,
   output dlr_pkg::dlr_cmd_type    cmd
);
   import dlr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_take;
   logic req_take;

   assign rsp_valid = (state_ff == ST_RUN);
   assign rsp_take  = rsp_valid & rsp_ready;
   // A new line may enter while the final pixel of the current one leaves.
   assign req_ready = (state_ff == ST_IDLE) | (rsp_take & status.last);
   assign req_take  = req_valid & req_ready;

   assign cmd.load    = req_take;
   assign cmd.advance = rsp_take & ~status.last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (rsp_take & status.last & ~req_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Per-axis position and remainder accumulators. The position numerator over
// 2*steps is kept as pos*2*steps + rem, with rem in [0, 2*steps).
// ----------------------------------------------------------------------------
module dlr_datapath #(
   parameter int GRID_SIZE = dlr_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dlr_pkg::req_type        req_data,
   input  dlr_pkg::dlr_cmd_type    cmd,
   output dlr_pkg::dlr_status_type status,
   output dlr_pkg::rsp_type        rsp_data
);
   import dlr_pkg::*;

   localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);
   localparam int REM_W = COORD_W + 1;   // 2*steps, up to 126
   localparam int DEL_W = COORD_W + 2;   // signed 2*delta
   localparam int SUM_W = COORD_W + 4;   // signed rem + 2*delta

   typedef struct packed {
      logic [COORD_W-1:0] pos;
      logic [REM_W-1:0]   rem;
   } axis_type;

   function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
      return (v > MAX_COORD) ? MAX_COORD : v;
   endfunction

   function automatic axis_type axis_step(input axis_type cur,
                                          input logic signed [DEL_W-1:0] two_d,
                                          input logic [REM_W-1:0] two_s);
      logic signed [SUM_W-1:0] sum;
      axis_type                nxt;
      sum = $signed({{(SUM_W-REM_W){1'b0}}, cur.rem})
            + {{(SUM_W-DEL_W){two_d[DEL_W-1]}}, two_d};
      nxt = cur;
      if (sum >= $signed({{(SUM_W-REM_W){1'b0}}, two_s})) begin
         nxt.rem = REM_W'(sum - $signed({{(SUM_W-REM_W){1'b0}}, two_s}));
         nxt.pos = cur.pos + 1'b1;
      end else if (sum < 0) begin
         nxt.rem = REM_W'(sum + $signed({{(SUM_W-REM_W){1'b0}}, two_s}));
         nxt.pos = cur.pos - 1'b1;
      end else begin
         nxt.rem = REM_W'(sum);
      end
      return nxt;
   endfunction

   logic [COORD_W-1:0]        sx, sy, ex, ey;
   logic signed [COORD_W:0]   dx, dy;
   logic [COORD_W-1:0]        adx, ady, steps;

   axis_type                  ax_ff, ax_in, ay_ff, ay_in;
   logic signed [DEL_W-1:0]   two_dx_ff, two_dy_ff;
   logic [REM_W-1:0]          two_s_ff;
   logic [COORD_W-1:0]        cnt_ff;
   logic [COLOR_W-1:0]        red_ff, green_ff, blue_ff;

   assign sx = clamp(req_data.start_x);
   assign sy = clamp(req_data.start_y);
   assign ex = clamp(req_data.end_x);
   assign ey = clamp(req_data.end_y);
   assign dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
   assign dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
   assign adx = COORD_W'(dx[COORD_W] ? -dx : dx);
   assign ady = COORD_W'(dy[COORD_W] ? -dy : dy);
   assign steps = (adx > ady) ? adx : ady;

   assign ax_in = axis_step(ax_ff, two_dx_ff, two_s_ff);
   assign ay_in = axis_step(ay_ff, two_dy_ff, two_s_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff     <= '{pos: sx, rem: REM_W'(steps)};
         ay_ff     <= '{pos: sy, rem: REM_W'(steps)};
         two_dx_ff <= DEL_W'(dx) <<< 1;
         two_dy_ff <= DEL_W'(dy) <<< 1;
         two_s_ff  <= {steps, 1'b0};
         red_ff    <= req_data.red_in;
         green_ff  <= req_data.green_in;
         blue_ff   <= req_data.blue_in;
      end else if (cmd.advance) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   // Remaining pixels after the one on the output; control state, so reset it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= steps;
      end else if (cmd.advance) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign status.last = (cnt_ff == '0);

   assign rsp_data.pixel_x    = ax_ff.pos;
   assign rsp_data.pixel_y    = ay_ff.pos;
   assign rsp_data.red_out    = red_ff;
   assign rsp_data.green_out  = green_ff;
   assign rsp_data.blue_out   = blue_ff;
   assign rsp_data.last_pixel = status.last;

endmodule

// File: src/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// Rasterizes one line request into a stream of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one line: two endpoints and a colour. rsp_* returns
//   steps+1 pixel items, steps = max(|dx|, |dy|), each with the line colour;
//   last_pixel marks the final one. Coordinates above GRID_SIZE-1 are
//   clamped to GRID_SIZE-1.
//   The first pixel is valid in the cycle after the request is taken.
//   Throughput: one pixel per cycle while rsp_ready is high, paced by the
//   pixel registers and the step counter; the next request is taken in
//   the same cycle as the final pixel of the current line leaves.
//   A stalled receiver holds the current pixel on rsp_data and freezes the
//   walk; no request is taken until the final pixel has gone.
//   Reset returns the block to idle, ready for a request; a line in
//   progress is dropped.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
   parameter int GRID_SIZE = dlr_pkg::GRID_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dlr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dlr_pkg::rsp_type rsp_data
);
   import dlr_pkg::*;

   dlr_cmd_type    cmd;
   dlr_status_type status;

   dlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlr_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // A request only enters when no pixel is pending, or the final one leaves.
   a_req_when_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |->
         (!rsp_valid || (rsp_ready && rsp_data.last_pixel)))
      else $error("request taken while a line is still in progress");

   a_pixel_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no pixel after an accepted request");

   // Consecutive pixels of one line differ by at most one column and keep the same red value.
   a_pixel_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last_pixel) |=>
         (rsp_valid && $stable(rsp_data.red_out) &&
          ((COORD_W'(rsp_data.pixel_x - $past(rsp_data.pixel_x)) == COORD_W'(0)) ||
           (COORD_W'(rsp_data.pixel_x - $past(rsp_data.pixel_x)) == COORD_W'(1)) ||
           (COORD_W'(rsp_data.pixel_x - $past(rsp_data.pixel_x)) == {COORD_W{1'b1}}))))
      else $error("pixel walk jumped by more than one column");

endmodule
